>>> rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register indexes, reset values and the config bundle.
// ----------------------------------------------------------------------------
package ppid_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned DB_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_LOWER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd7;

  localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST = 16'sd1000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST = -16'sd1000;
  localparam logic signed [ACC_W-1:0]   ACCUM_UPPER_RST = 32'sd500;
  localparam logic signed [ACC_W-1:0]   ACCUM_LOWER_RST = -32'sd500;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [DRIVE_W-1:0] drive_upper;
    logic signed [DRIVE_W-1:0] drive_lower;
    logic signed [ACC_W-1:0]   accum_upper;
    logic signed [ACC_W-1:0]   accum_lower;
    logic        [DB_W-1:0]    deadband;
  } cfg_t;

endpackage

>>> rtl/ppid_if.sv
// ----------------------------------------------------------------------------
// ppid_if
// Valid/ready channels: sample items in, drive items out.
// ----------------------------------------------------------------------------
interface ppid_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] feedback;

  modport source (output valid, command, setpoint, feedback, input ready);
  modport sink   (input valid, command, setpoint, feedback, output ready);
endinterface

interface ppid_out_if import ppid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      clamped;

  modport source (output valid, drive, clamped, input ready);
  modport sink   (input valid, drive, clamped, output ready);
endinterface

>>> rtl/ppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppid_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module ppid_cfg_regs import ppid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.drive_upper <= DRIVE_UPPER_RST;
      cfg_q.drive_lower <= DRIVE_LOWER_RST;
      cfg_q.accum_upper <= ACCUM_UPPER_RST;
      cfg_q.accum_lower <= ACCUM_LOWER_RST;
      cfg_q.deadband    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:      cfg_q.gain_p      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:      cfg_q.gain_i      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:      cfg_q.gain_d      <= cfg_data_i[GAIN_W-1:0];
        CFG_DRIVE_UPPER: cfg_q.drive_upper <= cfg_data_i[DRIVE_W-1:0];
        CFG_DRIVE_LOWER: cfg_q.drive_lower <= cfg_data_i[DRIVE_W-1:0];
        CFG_ACCUM_UPPER: cfg_q.accum_upper <= cfg_data_i[ACC_W-1:0];
        CFG_ACCUM_LOWER: cfg_q.accum_lower <= cfg_data_i[ACC_W-1:0];
        CFG_DEADBAND:    cfg_q.deadband    <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ppid_err_accum.sv
// ----------------------------------------------------------------------------
// ppid_err_accum
// Input register, error with dead zone, clamped accumulator and error delta.
// The stage-two error and accumulator registers are the controller history.
// ----------------------------------------------------------------------------
module ppid_err_accum import ppid_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_command_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_feedback_i,
  output logic                           st_valid_o,
  input  logic                           st_ready_i,
  output logic                           st_command_o,
  output logic signed [SAMPLE_WIDTH:0]   st_err_o,
  output logic signed [SAMPLE_WIDTH+1:0] st_delta_o,
  output logic signed [ACC_W-1:0]        st_acc_o
);

  localparam int unsigned ERR_W = SAMPLE_WIDTH + 1;
  localparam int unsigned DEL_W = SAMPLE_WIDTH + 2;
  localparam int unsigned CMP_W = ((ERR_W > DB_W + 1) ? ERR_W : (DB_W + 1)) + 1;
  localparam int unsigned SUM_W = ACC_W + 1;

  logic                           v1_q;
  logic                           cmd1_q;
  logic signed [SAMPLE_WIDTH-1:0] sp1_q, fb1_q;
  logic                           v2_q;
  logic                           cmd2_q;
  logic signed [ERR_W-1:0]        err_q, err_d;
  logic signed [DEL_W-1:0]        del_q, del_d;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  logic                           s1_go;
  logic signed [ERR_W-1:0]        err_raw;
  logic signed [CMP_W-1:0]        err_ext, db_ext;
  logic signed [SUM_W-1:0]        acc_sum, acc_hi, acc_lo, acc_t;

  assign s1_go      = v1_q && (!v2_q || st_ready_i);
  assign in_ready_o = !v1_q || s1_go;

  always_comb begin
    err_raw = ERR_W'(sp1_q) - ERR_W'(fb1_q);
    err_ext = CMP_W'(err_raw);
    db_ext  = $signed(CMP_W'(cfg_i.deadband));
    err_d   = ((err_ext > -db_ext) && (err_ext < db_ext)) ? '0 : err_raw;

    acc_sum = SUM_W'(acc_q) + SUM_W'(err_d);
    acc_hi  = SUM_W'(cfg_i.accum_upper);
    acc_lo  = SUM_W'(cfg_i.accum_lower);
    acc_t   = (acc_sum > acc_hi) ? acc_hi : acc_sum;
    acc_t   = (acc_t < acc_lo) ? acc_lo : acc_t;
    acc_d   = acc_t[ACC_W-1:0];

    del_d   = DEL_W'(err_d) - DEL_W'(err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd1_q <= in_command_i;
      sp1_q  <= in_setpoint_i;
      fb1_q  <= in_feedback_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      cmd2_q <= 1'b0;
      err_q  <= '0;
      acc_q  <= '0;
      del_q  <= '0;
    end else begin
      if (s1_go) begin
        v2_q   <= 1'b1;
        cmd2_q <= cmd1_q;
        if (cmd1_q) begin
          err_q <= '0;
          acc_q <= '0;
          del_q <= '0;
        end else begin
          err_q <= err_d;
          acc_q <= acc_d;
          del_q <= del_d;
        end
      end else if (st_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  assign st_valid_o   = v2_q;
  assign st_command_o = cmd2_q;
  assign st_err_o     = err_q;
  assign st_delta_o   = del_q;
  assign st_acc_o     = acc_q;

endmodule

>>> rtl/ppid_mult.sv
// ----------------------------------------------------------------------------
// ppid_mult
// Registered gain products for the P, I and D terms.
// ----------------------------------------------------------------------------
module ppid_mult import ppid_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cfg_t                                    cfg_i,
  input  logic                                    st_valid_i,
  output logic                                    st_ready_o,
  input  logic                                    st_command_i,
  input  logic signed [SAMPLE_WIDTH:0]            st_err_i,
  input  logic signed [SAMPLE_WIDTH+1:0]          st_delta_i,
  input  logic signed [ACC_W-1:0]                 st_acc_i,
  output logic                                    pr_valid_o,
  input  logic                                    pr_ready_i,
  output logic                                    pr_command_o,
  output logic signed [SAMPLE_WIDTH+GAIN_W:0]     pr_p_o,
  output logic signed [ACC_W+GAIN_W-1:0]          pr_i_o,
  output logic signed [SAMPLE_WIDTH+GAIN_W+1:0]   pr_d_o
);

  localparam int unsigned PP_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int unsigned PI_W = ACC_W + GAIN_W;
  localparam int unsigned PD_W = SAMPLE_WIDTH + GAIN_W + 2;

  logic                   v_q;
  logic                   cmd_q;
  logic signed [PP_W-1:0] pp_q, pp_d;
  logic signed [PI_W-1:0] pi_q, pi_d;
  logic signed [PD_W-1:0] pd_q, pd_d;
  logic                   go;

  assign go         = st_valid_i && (!v_q || pr_ready_i);
  assign st_ready_o = !v_q || pr_ready_i;

  always_comb begin
    pp_d = PP_W'(cfg_i.gain_p) * PP_W'(st_err_i);
    pi_d = PI_W'(cfg_i.gain_i) * PI_W'(st_acc_i);
    pd_d = PD_W'(cfg_i.gain_d) * PD_W'(st_delta_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (st_ready_o) begin
      v_q <= st_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      cmd_q <= st_command_i;
      pp_q  <= pp_d;
      pi_q  <= pi_d;
      pd_q  <= pd_d;
    end
  end

  assign pr_valid_o   = v_q;
  assign pr_command_o = cmd_q;
  assign pr_p_o       = pp_q;
  assign pr_i_o       = pi_q;
  assign pr_d_o       = pd_q;

endmodule

>>> rtl/ppid_out.sv
// ----------------------------------------------------------------------------
// ppid_out
// Term sum, Q-format shift, drive clamp and the result register.
// ----------------------------------------------------------------------------
module ppid_out import ppid_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  pr_valid_i,
  output logic                                  pr_ready_o,
  input  logic                                  pr_command_i,
  input  logic signed [SAMPLE_WIDTH+GAIN_W:0]   pr_p_i,
  input  logic signed [ACC_W+GAIN_W-1:0]        pr_i_i,
  input  logic signed [SAMPLE_WIDTH+GAIN_W+1:0] pr_d_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [DRIVE_W-1:0]             out_drive_o,
  output logic                                  out_clamped_o
);

  localparam int unsigned PI_W  = ACC_W + GAIN_W;
  localparam int unsigned PD_W  = SAMPLE_WIDTH + GAIN_W + 2;
  localparam int unsigned SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

  logic                      v_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      clamped_q, clamped_d;
  logic                      go;

  logic signed [SUM_W-1:0]   sum, shifted, hi, lo;
  logic                      clip_hi, clip_lo;

  assign go         = pr_valid_i && (!v_q || out_ready_i);
  assign pr_ready_o = !v_q || out_ready_i;

  always_comb begin
    sum     = SUM_W'(pr_p_i) + SUM_W'(pr_i_i) + SUM_W'(pr_d_i);
    shifted = sum >>> GAIN_FRAC_BITS;
    hi      = SUM_W'(cfg_i.drive_upper);
    lo      = SUM_W'(cfg_i.drive_lower);
    clip_hi = shifted > hi;
    clip_lo = clip_hi ? (hi < lo) : (shifted < lo);
    if (pr_command_i) begin
      drive_d   = '0;
      clamped_d = 1'b0;
    end else begin
      if (clip_lo) begin
        drive_d = cfg_i.drive_lower;
      end else if (clip_hi) begin
        drive_d = cfg_i.drive_upper;
      end else begin
        drive_d = shifted[DRIVE_W-1:0];
      end
      clamped_d = clip_hi || clip_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (pr_ready_o) begin
      v_q <= pr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o   = v_q;
  assign out_drive_o   = drive_q;
  assign out_clamped_o = clamped_q;

endmodule

>>> rtl/positional_pid_controller.sv
// ----------------------------------------------------------------------------
// positional_pid_controller
// Positional PID with dead zone, clamped integral and clamped drive. Items
// are taken one per clock while the output does not stall; each accepted
// item passes the input, error/accumulator, product and result registers,
// and a stalled output only holds up the stages behind it. The integral
// and the last error live in the error/accumulator stage, which is the
// only feedback loop. A clear item zeroes that history and returns a drive
// of zero. Gains are signed fixed point with GAIN_FRAC_BITS fraction bits;
// the term sum is shifted right arithmetically by that amount. The user
// must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only while no
// item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module positional_pid_controller import ppid_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppid_in_if.sink               in_i,
  ppid_out_if.source            out_o
);

  cfg_t cfg;

  logic                                  st_valid, st_ready, st_command;
  logic signed [SAMPLE_WIDTH:0]          st_err;
  logic signed [SAMPLE_WIDTH+1:0]        st_delta;
  logic signed [ACC_W-1:0]               st_acc;

  logic                                  pr_valid, pr_ready, pr_command;
  logic signed [SAMPLE_WIDTH+GAIN_W:0]   pr_p;
  logic signed [ACC_W+GAIN_W-1:0]        pr_i;
  logic signed [SAMPLE_WIDTH+GAIN_W+1:0] pr_d;

  ppid_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ppid_err_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_err (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_command_i  (in_i.command),
    .in_setpoint_i (in_i.setpoint),
    .in_feedback_i (in_i.feedback),
    .st_valid_o    (st_valid),
    .st_ready_i    (st_ready),
    .st_command_o  (st_command),
    .st_err_o      (st_err),
    .st_delta_o    (st_delta),
    .st_acc_o      (st_acc)
  );

  ppid_mult #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .st_valid_i   (st_valid),
    .st_ready_o   (st_ready),
    .st_command_i (st_command),
    .st_err_i     (st_err),
    .st_delta_i   (st_delta),
    .st_acc_i     (st_acc),
    .pr_valid_o   (pr_valid),
    .pr_ready_i   (pr_ready),
    .pr_command_o (pr_command),
    .pr_p_o       (pr_p),
    .pr_i_o       (pr_i),
    .pr_d_o       (pr_d)
  );

  ppid_out #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pr_valid_i    (pr_valid),
    .pr_ready_o    (pr_ready),
    .pr_command_i  (pr_command),
    .pr_p_i        (pr_p),
    .pr_i_i        (pr_i),
    .pr_d_i        (pr_d),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_drive_o   (out_o.drive),
    .out_clamped_o (out_o.clamped)
  );

endmodule
